### hdl/u2e_pkg.sv
// shared types, codes and character helpers for the utf-8 escaper
package u2e_pkg;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [15:0] CapReset = 16'd256;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_BIG = 2'd1;
  localparam logic [1:0] STAT_LEN = 2'd2;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_U_LO = 8'h75;
  localparam logic [7:0] CH_U_HI = 8'h55;

  // rendering class of one codepoint
  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_PLAIN = 3'd1,
    K_ESC   = 3'd2,
    K_HEX   = 3'd3,
    K_U4    = 3'd4,
    K_U8    = 3'd5
  } kind_t;

  // back end step
  typedef enum logic [2:0] {
    ST_CP   = 3'b001,
    ST_AT   = 3'b010,
    ST_TERM = 3'b100
  } step_t;

  // one job from front to back
  typedef struct packed {
    kind_t       kind;
    logic [20:0] cp;
    logic        last;
    logic        at_sfx;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
  endfunction

  function automatic logic is_esc(input logic [20:0] cp);
    is_esc = (cp >= 21'h07 && cp <= 21'h0D) || cp == 21'h5C;
  endfunction

  function automatic logic [7:0] esc_letter(input logic [7:0] cp);
    logic [7:0] r;
    unique case (cp)
      8'h07:   r = 8'h61; // a
      8'h08:   r = 8'h62; // b
      8'h0C:   r = 8'h66; // f
      8'h0A:   r = 8'h6E; // n
      8'h0D:   r = 8'h72; // r
      8'h09:   r = 8'h74; // t
      8'h0B:   r = 8'h76; // v
      default: r = CH_BSL;
    endcase
    esc_letter = r;
  endfunction

  function automatic kind_t classify(input logic [20:0] cp);
    kind_t k;
    if (cp < 21'h0F || cp == 21'h5C) begin
      k = is_esc(cp) ? K_ESC : K_HEX;
    end else if (cp >= 21'h20 && cp <= 21'h7F) begin
      k = K_PLAIN;
    end else if (cp > 21'hFFFF) begin
      k = K_U8;
    end else begin
      k = K_U4;
    end
    classify = k;
  endfunction

  function automatic logic [3:0] kind_len(input kind_t k);
    logic [3:0] n;
    unique case (k)
      K_PLAIN: n = 4'd1;
      K_ESC:   n = 4'd2;
      K_HEX:   n = 4'd4;
      K_U4:    n = 4'd6;
      K_U8:    n = 4'd10;
      default: n = 4'd0;
    endcase
    kind_len = n;
  endfunction

endpackage

### hdl/utf8_to_escaped_ascii.sv
// top level: utf-8 to escaped ascii converter with capacity checking
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | in_src_byte, in_last_byte
//  out     | out_valid / out_ready| out_char, out_status, out_end_of_run,
//          |                      | out_string_done
//  cfg     | cfg_we               | cfg_wdata (dst_capacity)
//
// one source byte accepted per cycle while the 4-deep job queue has room
// one result beat per cycle unless out_ready stalls; escapes expand to up to 12 beats
//   per byte, set by the single character generator in the back end
// a byte that finishes nothing (utf-8 lead byte) and is not the last pushes no job
//   and never reaches the back end; jobs of an aborted string are dropped without output
// synchronous active-low reset; capacity resets to 256, all string state clears
// output stalls fill the queue and then drop in_ready; input stalls just starve
module utf8_to_escaped_ascii import u2e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_src_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic [1:0]  out_status,
  output logic        out_end_of_run,
  output logic        out_string_done,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] cap_r;
  logic        q_push, q_full, q_pop, q_empty;
  job_t        push_job, head;

  // output buffer size in characters, terminator included
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CapReset;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // decode and classify
  u2e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_src_byte  (in_src_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  // decouples decode from character expansion
  u2e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  // character expansion, counting and error reporting
  u2e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cap             (cap_r),
    .q_empty         (q_empty),
    .head            (head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_status      (out_status),
    .out_end_of_run  (out_end_of_run),
    .out_string_done (out_string_done)
  );

endmodule

### hdl/u2e_front.sv
// front end: accepts source bytes, assembles codepoints and classifies them
module u2e_front import u2e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_src_byte,
  input  logic       in_last_byte,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic        take;
  logic        emit;
  logic [20:0] cpv;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    emit     = 1'b0;
    cpv      = '0;
    priority if (pend_r != 2'd0) begin
      acc_nxt  = {acc_r[14:0], in_src_byte[5:0]};
      pend_nxt = pend_r - 2'd1;
      emit     = (pend_r == 2'd1);
      cpv      = {acc_r[14:0], in_src_byte[5:0]};
    end else if (in_src_byte[7:3] == 5'b11110) begin
      acc_nxt  = {18'd0, in_src_byte[2:0]};
      pend_nxt = 2'd3;
    end else if (in_src_byte[7:4] == 4'b1110) begin
      acc_nxt  = {17'd0, in_src_byte[3:0]};
      pend_nxt = 2'd2;
    end else if (in_src_byte[7:5] == 3'b110) begin
      acc_nxt  = {16'd0, in_src_byte[4:0]};
      pend_nxt = 2'd1;
    end else begin
      emit = 1'b1;
      cpv  = {13'd0, in_src_byte};
    end
    // end of string drops any unfinished sequence
    if (in_last_byte) begin
      pend_nxt = 2'd0;
      acc_nxt  = '0;
    end
  end

  assign q_push        = take && (emit || in_last_byte);
  assign q_job.kind    = emit ? classify(cpv) : K_NONE;
  assign q_job.cp      = cpv;
  assign q_job.last    = in_last_byte;
  assign q_job.at_sfx  = in_last_byte && (in_src_byte == CH_SP || in_src_byte == CH_AT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      acc_r  <= '0;
    end else if (take) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

### hdl/u2e_queue.sv
// small job fifo between front and back
module u2e_queue import u2e_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t             mem_r [QDepth];
  logic [QAw-1:0]   wp_r, rp_r;
  logic [QAw:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QAw+1)'(QDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue pushed while full");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r <= (QAw+1)'(QDepth))
    else $error("queue count out of range");

endmodule

### hdl/u2e_back.sv
// back end: expands jobs into characters, checks capacity, holds the output register
module u2e_back import u2e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] cap,
  input  logic        q_empty,
  input  job_t        head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic [1:0]  out_status,
  output logic        out_end_of_run,
  output logic        out_string_done
);

  logic        fresh_r;
  step_t       stage_r, stage_nxt, cur_stage, start_stage;
  logic [3:0]  idx_r, cur_idx;
  logic [15:0] w_r;
  logic        err_r;
  logic        ov_r;
  logic [7:0]  ch_r;
  logic [1:0]  st_r;
  logic        eor_r, done_r;

  logic        slot_free, drop, work;
  logic        fail, end_ok, done, job_end;
  logic [1:0]  st;
  logic [7:0]  ch;
  logic [3:0]  len;
  logic [16:0] w17, cap17;

  function automatic logic [7:0] cp_char(input kind_t k, input logic [20:0] cp,
                                         input logic [3:0] i);
    logic [31:0] cp32;
    logic [3:0]  d;
    logic [2:0]  ni;
    logic [7:0]  r;
    cp32 = {11'd0, cp};
    d    = i - 4'd2;
    ni   = (k == K_U8) ? (3'd7 - d[2:0]) : (3'd3 - d[2:0]);
    unique case (k)
      K_PLAIN: r = cp[7:0];
      K_ESC:   r = (i == 4'd0) ? CH_BSL : esc_letter(cp[7:0]);
      K_HEX: begin
        unique case (i[1:0])
          2'd0:    r = CH_BSL;
          2'd1:    r = CH_X;
          2'd2:    r = hex_char(cp[7:4]);
          default: r = hex_char(cp[3:0]);
        endcase
      end
      K_U4, K_U8: begin
        if (i == 4'd0)      r = CH_BSL;
        else if (i == 4'd1) r = (k == K_U8) ? CH_U_HI : CH_U_LO;
        else                r = hex_char(cp32[{ni, 2'b00} +: 4]);
      end
      default: r = CH_NUL;
    endcase
    cp_char = r;
  endfunction

  assign slot_free = !ov_r || out_ready;
  assign drop      = !q_empty && err_r;
  assign work      = !q_empty && !err_r && slot_free;

  assign start_stage = (head.kind != K_NONE) ? ST_CP : (head.at_sfx ? ST_AT : ST_TERM);
  assign cur_stage   = fresh_r ? start_stage : stage_r;
  assign cur_idx     = fresh_r ? 4'd0 : idx_r;
  assign len         = kind_len(head.kind);
  assign w17         = {1'b0, w_r};
  assign cap17       = {1'b0, cap};

  always_comb begin
    fail      = 1'b0;
    st        = STAT_BIG;
    ch        = CH_NUL;
    end_ok    = 1'b0;
    done      = 1'b0;
    stage_nxt = cur_stage;
    unique case (cur_stage)
      ST_CP: begin
        priority if (head.kind == K_HEX && cur_idx == 4'd0) begin
          // hex escape goes out whole or not at all
          fail = (cap17 <= w17 + 17'd4);
        end else if ((head.kind == K_U4 || head.kind == K_U8) && cur_idx == 4'd2) begin
          fail = (cap17 < w17 + ((head.kind == K_U8) ? 17'd8 : 17'd4));
          st   = STAT_LEN;
        end else begin
          fail = (w_r >= cap);
        end
        ch = cp_char(head.kind, head.cp, cur_idx);
        if (cur_idx == len - 4'd1) begin
          end_ok    = !head.last;
          stage_nxt = head.at_sfx ? ST_AT : ST_TERM;
        end
      end
      ST_AT: begin
        fail      = (w_r >= cap);
        st        = STAT_LEN;
        ch        = CH_AT;
        stage_nxt = ST_TERM;
      end
      ST_TERM: begin
        fail   = (w_r >= cap);
        ch     = CH_NUL;
        done   = 1'b1;
        end_ok = 1'b1;
      end
      default: begin
        fail = 1'b1;
      end
    endcase
  end

  assign job_end = fail || end_ok;
  assign q_pop   = drop || (work && job_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= 1'b1;
      stage_r <= ST_CP;
      idx_r   <= '0;
      w_r     <= '0;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (slot_free) ov_r <= work;
      if (drop) begin
        // aborted string: swallow jobs until its last one
        if (head.last) begin
          err_r <= 1'b0;
          w_r   <= '0;
        end
      end else if (work) begin
        fresh_r <= job_end;
        if (!job_end) begin
          stage_r <= stage_nxt;
          idx_r   <= (stage_nxt == ST_CP) ? cur_idx + 4'd1 : 4'd0;
        end
        if (job_end && head.last) begin
          w_r   <= '0;
          err_r <= 1'b0;
        end else if (fail) begin
          err_r <= 1'b1;
        end else begin
          w_r <= w_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      ch_r   <= fail ? CH_NUL : ch;
      st_r   <= fail ? st : STAT_OK;
      eor_r  <= job_end;
      done_r <= fail || done;
    end
  end

  assign out_valid       = ov_r;
  assign out_char        = ch_r;
  assign out_status      = st_r;
  assign out_end_of_run  = eor_r;
  assign out_string_done = done_r;

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
      ov_r && st_r != STAT_OK |-> ch_r == CH_NUL && done_r && eor_r)
    else $error("error beat is malformed");
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
      ov_r && done_r |-> eor_r)
    else $error("string end without end of run");
  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
      !fresh_r |-> !q_empty)
    else $error("job in progress but queue empty");

endmodule
